### rtl/dda_pkg.sv
package dda_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // load endpoints, emit first pixel, arm divider
		logic div_en;  // one quotient bit per cycle
		logic adv;     // add increments, emit pixel
	} dda_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic zero_len;   // incoming endpoints are equal
		logic div_last;   // final divider iteration this cycle
		logic last_step;  // one step left on the current line
		logic out_full;   // output register holds a beat not taken this cycle
	} dda_sts_t;

endpackage

### rtl/dda_ctrl.sv
module dda_ctrl
	import dda_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tuser,
	output logic     s_tready,
	input  dda_sts_t sts,
	output dda_cmd_t cmd
);

	state_t state_q, state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q != ST_DIV) && !sts.out_full;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.div_en = 1'b0;
		cmd.adv    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// step beats while idle are taken and dropped
				if (acc && s_tuser) begin
					cmd.start = 1'b1;
					state_d   = sts.zero_len ? ST_IDLE : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (acc && s_tuser) begin
					cmd.start = 1'b1;
					state_d   = sts.zero_len ? ST_IDLE : ST_DIV;
				end else if (acc) begin
					cmd.adv = 1'b1;
					if (sts.last_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_div_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !s_tready)
		else $error("input taken while divider busy");

	a_div_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && sts.div_last |=> state_q == ST_RUN)
		else $error("divider end did not enter run");

	a_start_divides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && !sts.zero_len |=> state_q == ST_DIV)
		else $error("nonzero line did not start divider");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv && sts.last_step |=> state_q == ST_IDLE)
		else $error("line did not end after final step");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.div_en, cmd.adv}))
		else $error("conflicting datapath commands");

endmodule

### rtl/dda_dp.sv
module dda_dp
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [4*COORD_BITS-1:0] ends,
	input  dda_cmd_t                cmd,
	output dda_sts_t                sts,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic                    out_last
);

	localparam int C  = COORD_BITS;
	localparam int P  = COORD_BITS + FRAC_BITS;
	localparam int CW = $clog2(P);

	logic [C-1:0] xs, ys, xe, ye;
	logic [C:0]   dx, dy;
	logic [C-1:0] mag_x, mag_y, steps;

	logic [P-1:0]  pos_x_q, pos_y_q;
	logic [P-1:0]  num_x_q, num_y_q;   // dividend in, quotient out
	logic [C-1:0]  rem_x_q, rem_y_q;
	logic          neg_x_q, neg_y_q;
	logic [C-1:0]  steps_q, left_q;
	logic [CW-1:0] cnt_q;

	logic [C:0]   trial_x, trial_y;
	logic         ge_x, ge_y;
	logic [C:0]   diff_x, diff_y;
	logic [P-1:0] inc_x, inc_y, nxt_x, nxt_y;

	logic         valid_q, last_q;
	logic [C-1:0] px_q, py_q;

	assign xs = ends[C-1:0];
	assign ys = ends[2*C-1:C];
	assign xe = ends[3*C-1:2*C];
	assign ye = ends[4*C-1:3*C];

	assign dx    = {1'b0, xe} - {1'b0, xs};
	assign dy    = {1'b0, ye} - {1'b0, ys};
	assign mag_x = dx[C] ? C'(-dx) : dx[C-1:0];
	assign mag_y = dy[C] ? C'(-dy) : dy[C-1:0];
	assign steps = (mag_x > mag_y) ? mag_x : mag_y;

	// restoring divider, one bit per cycle on each axis
	assign trial_x = {rem_x_q, num_x_q[P-1]};
	assign trial_y = {rem_y_q, num_y_q[P-1]};
	assign ge_x    = trial_x >= {1'b0, steps_q};
	assign ge_y    = trial_y >= {1'b0, steps_q};
	assign diff_x  = trial_x - {1'b0, steps_q};
	assign diff_y  = trial_y - {1'b0, steps_q};

	assign inc_x = neg_x_q ? (~num_x_q + P'(1)) : num_x_q;
	assign inc_y = neg_y_q ? (~num_y_q + P'(1)) : num_y_q;
	assign nxt_x = pos_x_q + inc_x;
	assign nxt_y = pos_y_q + inc_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.div_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.start || cmd.adv) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_x_q <= {xs, FRAC_BITS'(0)};
			pos_y_q <= {ys, FRAC_BITS'(0)};
			num_x_q <= {mag_x, FRAC_BITS'(0)};
			num_y_q <= {mag_y, FRAC_BITS'(0)};
			rem_x_q <= '0;
			rem_y_q <= '0;
			neg_x_q <= dx[C];
			neg_y_q <= dy[C];
			steps_q <= steps;
			left_q  <= steps;
			px_q    <= xs;
			py_q    <= ys;
			last_q  <= (steps == '0);
		end else if (cmd.div_en) begin
			num_x_q <= {num_x_q[P-2:0], ge_x};
			num_y_q <= {num_y_q[P-2:0], ge_y};
			rem_x_q <= ge_x ? diff_x[C-1:0] : trial_x[C-1:0];
			rem_y_q <= ge_y ? diff_y[C-1:0] : trial_y[C-1:0];
		end else if (cmd.adv) begin
			pos_x_q <= nxt_x;
			pos_y_q <= nxt_y;
			left_q  <= left_q - C'(1);
			px_q    <= nxt_x[P-1:FRAC_BITS];
			py_q    <= nxt_y[P-1:FRAC_BITS];
			last_q  <= (left_q == C'(1));
		end
	end

	assign sts.zero_len  = (steps == '0);
	assign sts.div_last  = (cnt_q == CW'(P - 1));
	assign sts.last_step = (left_q == C'(1));
	assign sts.out_full  = valid_q && !out_ready;

	assign out_valid = valid_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign out_last  = last_q;

endmodule

### rtl/dda_line_rasterizer_top.sv
// Channel  Dir  Beat fields (lowest bit first)
// s_*      in   tuser: func | tdata: x_start, y_start, x_end, y_end
// m_*      out  tdata: pixel_x, pixel_y | tlast: last
//
// Start beat: accepted, first pixel leaves from the output register on the next cycle,
// then the input stalls while the bit-per-cycle restoring divider forms both increments.
// Zero-length lines skip the divider. Step beats while idle are dropped.
// Step beats: one per cycle while m_tready does not stall, one adder pass per pixel.
// Reset clears the state machine, output valid and divider count; no clearing pass.
// A held m_tready low stalls s_tready once the single output register is full.
module dda_line_rasterizer_top
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,  // x_start, y_start, x_end, y_end
	input  logic                                   s_tuser,  // func: 1 start, 0 step
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,  // pixel_x, pixel_y
	output logic                                   m_tlast   // final pixel of the line
);

	localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

	dda_cmd_t              cmd;
	dda_sts_t              sts;
	logic [COORD_BITS-1:0] pixel_x, pixel_y;

	// sequencer: idle / divide / run
	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// position registers, divider and output register
	dda_dp #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ends      (s_tdata[4*COORD_BITS-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.out_last  (m_tlast)
	);

	assign m_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

### tb/sv/dda_line_rasterizer_top_tb.sv
module dda_line_rasterizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 10;            // coordinate bits
	localparam int FW = 16;            // fraction bits
	localparam int PW = CW + FW;       // position width
	localparam int IN_W  = ((4*CW+7)/8)*8;
	localparam int OUT_W = ((2*CW+7)/8)*8;
	localparam int COORD_MAX = (1 << CW) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 64;  // divider pass plus output register, with margin

	// func codes carried on s_tuser
	localparam logic FN_STEP  = 1'b0;
	localparam logic FN_START = 1'b1;

	typedef struct packed {
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic          lst;
	} pixel_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata  = '0;  // x_start, y_start, x_end, y_end
	logic              s_tuser  = 1'b0; // func
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;        // pixel_x, pixel_y
	logic              m_tlast;

	dda_line_rasterizer_top #(
		.COORD_BITS(CW),
		.FRAC_BITS (FW)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// idle odds in percent, changed per phase
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	int beats_sent = 0;
	int err_cnt    = 0;
	int cycle_cnt  = 0;

	pixel_t pixel_q[$];  // pixels predicted, oldest first

	// line state of the predictor
	logic [PW-1:0]        pos_x, pos_y;
	logic signed [PW:0]   inc_x, inc_y;
	logic [CW:0]          steps_left;
	logic                 line_busy;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run guard: a hang in the handshake ends here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("dda_line_rasterizer_top_tb: errors");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_idle_pct);

	function automatic pixel_t cur_pixel(input logic lst);
		pixel_t p;
		p.px  = pos_x[PW-1:FW];
		p.py  = pos_y[PW-1:FW];
		p.lst = lst;
		return p;
	endfunction

	// append one predicted pixel at the tail
	function automatic void queue_pixel(input pixel_t p);
		pixel_q = {pixel_q, p};
	endfunction

	// Advance the line model by one accepted input beat; queue the pixel it yields.
	function automatic void rasterize_beat(input logic func, input logic [IN_W-1:0] data);
		logic [CW-1:0] xs, ys, xe, ye;
		int     dx, dy, ax, ay, n;
		longint qx, qy;
		xs = data[0*CW +: CW];
		ys = data[1*CW +: CW];
		xe = data[2*CW +: CW];
		ye = data[3*CW +: CW];
		if (func == FN_START) begin
			dx = int'(xe) - int'(xs);
			dy = int'(ye) - int'(ys);
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			n  = (ax > ay) ? ax : ay;
			pos_x = {xs, {FW{1'b0}}};
			pos_y = {ys, {FW{1'b0}}};
			if (n == 0) begin
				// zero-length line: single flagged pixel, stays idle
				inc_x = '0;
				inc_y = '0;
				steps_left = '0;
				line_busy = 1'b0;
				queue_pixel(cur_pixel(1'b1));
			end else begin
				// increments truncated toward zero
				qx = (longint'(ax) << FW) / n;
				qy = (longint'(ay) << FW) / n;
				inc_x = (PW+1)'((dx < 0) ? -qx : qx);
				inc_y = (PW+1)'((dy < 0) ? -qy : qy);
				steps_left = (CW+1)'(n);
				line_busy = 1'b1;
				queue_pixel(cur_pixel(1'b0));
			end
		end else if (line_busy) begin
			pos_x = pos_x + inc_x[PW-1:0];
			pos_y = pos_y + inc_y[PW-1:0];
			steps_left = steps_left - 1'b1;
			if (steps_left == 0)
				line_busy = 1'b0;
			queue_pixel(cur_pixel(steps_left == 0));
		end
		// step while idle: dropped, nothing expected
	endfunction

	// Both handshakes are judged at the falling edge, where every signal is settled
	// for the rising edge that follows. Input prediction goes first so a pixel can
	// never be checked before its beat has been modeled.
	always @(negedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				rasterize_beat(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					err_cnt++;
					$display("%0t: pixel beat expected none actual x=%0d y=%0d last=%0b",
						$realtime, m_tdata[0 +: CW], m_tdata[CW +: CW], m_tlast);
				end else begin
					want = pixel_q.pop_front();
					if (m_tdata[0 +: CW] !== want.px) begin
						err_cnt++;
						$display("%0t: pixel_x expected %0d actual %0d", $realtime,
							want.px, m_tdata[0 +: CW]);
					end
					if (m_tdata[CW +: CW] !== want.py) begin
						err_cnt++;
						$display("%0t: pixel_y expected %0d actual %0d", $realtime,
							want.py, m_tdata[CW +: CW]);
					end
					if (m_tlast !== want.lst) begin
						err_cnt++;
						$display("%0t: last expected %0b actual %0b", $realtime,
							want.lst, m_tlast);
					end
				end
			end
		end
	end

	// One input beat. Entered at a rising edge, returns at the edge that took it.
	// tvalid stays up across back-to-back beats; it drops only for a gap.
	task automatic send_beat(input logic func, input logic [CW-1:0] xs, ys, xe, ye);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= IN_W'({ye, xe, ys, xs});
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		beats_sent++;
	endtask

	// start beat followed by a number of step beats
	task automatic draw_line(input logic [CW-1:0] xs, ys, xe, ye, input int n_steps);
		send_beat(FN_START, xs, ys, xe, ye);
		repeat (n_steps)
			send_beat(FN_STEP, CW'($urandom()), CW'($urandom()), CW'($urandom()),
				CW'($urandom()));
	endtask

	// step beats with no line loaded must vanish
	task automatic test_idle_steps();
		send_beat(FN_STEP, '1, '1, '1, '1);
		send_beat(FN_STEP, '0, '0, '0, '0);
	endtask

	// equal endpoints: one flagged pixel, no divider pass
	task automatic test_zero_length();
		send_beat(FN_START, '0, '0, '0, '0);
		send_beat(FN_START, '1, '1, '1, '1);
		send_beat(FN_START, 10'h2aa, 10'h155, 10'h2aa, 10'h155);
	endtask

	// fractional slope both ways; backward run gets one step past its end
	task automatic test_short_lines();
		draw_line(10'd5, 10'd5, 10'd9, 10'd7, 4);
		draw_line(10'd9, 10'd7, 10'd5, 10'd5, 5);  // one spare step lands while idle
	endtask

	// full-range lines dropped partway by a new start, then a short line run to its end
	task automatic test_restart();
		draw_line('0, '0, '1, '1, 2);
		draw_line('1, '0, '0, '1, 2);
		draw_line('1, '1, '0, '0, 1);
		draw_line(10'd3, 10'd3, 10'd4, 10'd3, 1);
	endtask

	// Mostly complete lines with random endpoints and small spans; some medium
	// spans, full-range lines cut short by a restart, overrun steps, and noise.
	task automatic test_random_lines(input int n_items);
		int goal, kind, reach, lo, hi, dx, dy, n, k;
		logic [CW-1:0] xs, ys, xe, ye;
		goal = beats_sent + n_items;
		while (beats_sent < goal) begin
			kind = $urandom_range(99);
			if (kind < 6) begin
				send_beat(logic'($urandom_range(1)), CW'($urandom()), CW'($urandom()),
					CW'($urandom()), CW'($urandom()));
			end else begin
				reach = (kind < 70) ? 15 : (kind < 90) ? 100 : COORD_MAX;
				xs = CW'($urandom());
				ys = CW'($urandom());
				lo = (int'(xs) - reach < 0) ? 0 : int'(xs) - reach;
				hi = (int'(xs) + reach > COORD_MAX) ? COORD_MAX : int'(xs) + reach;
				xe = CW'($urandom_range(hi, lo));
				lo = (int'(ys) - reach < 0) ? 0 : int'(ys) - reach;
				hi = (int'(ys) + reach > COORD_MAX) ? COORD_MAX : int'(ys) + reach;
				ye = CW'($urandom_range(hi, lo));
				dx = int'(xe) - int'(xs);
				dy = int'(ye) - int'(ys);
				dx = (dx < 0) ? -dx : dx;
				dy = (dy < 0) ? -dy : dy;
				n  = (dx > dy) ? dx : dy;
				k  = n;
				if (reach == COORD_MAX || $urandom_range(7) == 0)
					k = $urandom_range((n < 24) ? n : 24);
				else if ($urandom_range(9) == 0)
					k = n + $urandom_range(3, 1);
				draw_line(xs, ys, xe, ye, k);
			end
		end
	endtask

	initial begin
		line_busy  = 1'b0;
		steps_left = '0;
		pos_x = '0;
		pos_y = '0;
		inc_x = '0;
		inc_y = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase 1: sparse sender gaps, heavy backpressure
		src_idle_pct  = 26;
		sink_idle_pct = 69;
		test_idle_steps();
		test_zero_length();
		test_short_lines();
		test_restart();
		test_random_lines(280);

		// phase 2: roles swapped
		src_idle_pct  = 69;
		sink_idle_pct = 26;
		test_random_lines(280);

		// phase 3: full rate both sides
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_lines(280);

		s_tvalid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		// catch stray beats after the last expected pixel
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("dda_line_rasterizer_top_tb: clean");
		else
			$display("dda_line_rasterizer_top_tb: errors");
		$finish;
	end

endmodule

### files.f
rtl/dda_pkg.sv
rtl/dda_ctrl.sv
rtl/dda_dp.sv
rtl/dda_line_rasterizer_top.sv
tb/sv/dda_line_rasterizer_top_tb.sv
